// ===== rtl/cesd_pkg.sv =====
// ============================================================================
// cesd_pkg: shared types and constants of the C escape sequence decoder
// Result layout, the request handed from the decoder to the output queue,
// character codes and the saturating length counter width.
// ============================================================================
package cesd_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int COUNT_BITS  = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
    localparam int QUEUE_DEPTH = 3;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
    localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
    localparam logic [7:0] CHAR_LOWER_V   = 8'h76;
    localparam logic [7:0] CTRL_BEL       = 8'h07;
    localparam logic [7:0] CTRL_BS        = 8'h08;
    localparam logic [7:0] CTRL_FF        = 8'h0C;
    localparam logic [7:0] CTRL_LF        = 8'h0A;
    localparam logic [7:0] CTRL_CR        = 8'h0D;
    localparam logic [7:0] CTRL_HT        = 8'h09;
    localparam logic [7:0] CTRL_VT        = 8'h0B;
    localparam logic [4:0] OCTAL_PREFIX   = 5'b00110;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        string_end;
        logic [15:0] decoded_length;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/cesd_decode.sv =====
// ============================================================================
// cesd_decode: escape state and per-byte decode
// Holds the escape, octal and length state and turns one accepted source
// byte into zero, one or two results in a single combinational pass.
// ============================================================================
module cesd_decode
    import cesd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    output push_t      push
);

    logic                  escape_pending_reg, escape_pending_next;
    logic [1:0]            octal_count_reg, octal_count_next;
    logic [7:0]            octal_acc_reg, octal_acc_next;
    logic [COUNT_BITS-1:0] emitted_reg, emitted_next;

    localparam logic [COUNT_BITS-1:0] LENGTH_CAP = '1;

    function automatic result_t make_result(logic [7:0] b, logic e,
                                            logic [COUNT_BITS-1:0] len);
        result_t r;
        r.out_byte       = b;
        r.string_end     = e;
        r.decoded_length = 16'(len);
        r.run_last       = 1'b0;
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
        return (c == LENGTH_CAP) ? c : c + 1'b1;
    endfunction

    result_t               res_v [2];
    logic [1:0]            nres;
    logic [COUNT_BITS-1:0] cnt_v;
    logic [7:0]            acc_v;
    logic                  plain_v;
    logic                  end_v;
    logic                  is_octal;

    always_comb begin
        escape_pending_next = escape_pending_reg;
        octal_count_next    = octal_count_reg;
        octal_acc_next      = octal_acc_reg;
        cnt_v               = emitted_reg;
        res_v[0]            = '0;
        res_v[1]            = '0;
        nres                = 2'd0;
        plain_v             = 1'b0;
        end_v               = 1'b0;
        is_octal            = (in_byte[7:3] == OCTAL_PREFIX);
        acc_v               = {octal_acc_reg[4:0], in_byte[2:0]};

        if (octal_count_reg != 2'd0) begin
            if (is_octal) begin
                if (octal_count_reg == 2'd2) begin
                    res_v[nres[0]]   = make_result(acc_v, 1'b0, '0);
                    nres             = nres + 2'd1;
                    cnt_v            = sat_inc(cnt_v);
                    octal_count_next = 2'd0;
                    octal_acc_next   = '0;
                end else begin
                    octal_count_next = octal_count_reg + 2'd1;
                    octal_acc_next   = acc_v;
                end
            end else begin
                res_v[nres[0]]   = make_result(octal_acc_reg, 1'b0, '0);
                nres             = nres + 2'd1;
                cnt_v            = sat_inc(cnt_v);
                octal_count_next = 2'd0;
                octal_acc_next   = '0;
                plain_v          = 1'b1;
            end
        end else if (escape_pending_reg) begin
            escape_pending_next = 1'b0;
            if (is_octal) begin
                octal_count_next = 2'd1;
                octal_acc_next   = {5'b00000, in_byte[2:0]};
            end else begin
                unique case (in_byte)
                    CHAR_NUL: begin
                        end_v = 1'b1;
                    end
                    CHAR_LOWER_A, CHAR_LOWER_B, CHAR_LOWER_F, CHAR_LOWER_N,
                    CHAR_LOWER_R, CHAR_LOWER_T, CHAR_LOWER_V,
                    CHAR_QUOTE, CHAR_BACKSLASH: begin
                        res_v[nres[0]] = make_result(in_byte, 1'b0, '0);
                        case (in_byte)
                            CHAR_LOWER_A: res_v[nres[0]].out_byte = CTRL_BEL;
                            CHAR_LOWER_B: res_v[nres[0]].out_byte = CTRL_BS;
                            CHAR_LOWER_F: res_v[nres[0]].out_byte = CTRL_FF;
                            CHAR_LOWER_N: res_v[nres[0]].out_byte = CTRL_LF;
                            CHAR_LOWER_R: res_v[nres[0]].out_byte = CTRL_CR;
                            CHAR_LOWER_T: res_v[nres[0]].out_byte = CTRL_HT;
                            CHAR_LOWER_V: res_v[nres[0]].out_byte = CTRL_VT;
                            default:      res_v[nres[0]].out_byte = in_byte;
                        endcase
                        nres  = nres + 2'd1;
                        cnt_v = sat_inc(cnt_v);
                    end
                    default: begin
                        res_v[0] = make_result(CHAR_BACKSLASH, 1'b0, '0);
                        res_v[1] = make_result(in_byte, 1'b0, '0);
                        nres     = 2'd2;
                        cnt_v    = sat_inc(sat_inc(cnt_v));
                    end
                endcase
            end
        end else begin
            plain_v = 1'b1;
        end

        if (plain_v) begin
            if (in_byte == CHAR_NUL) begin
                end_v = 1'b1;
            end else if (in_byte == CHAR_BACKSLASH) begin
                escape_pending_next = 1'b1;
            end else begin
                res_v[nres[0]] = make_result(in_byte, 1'b0, '0);
                nres           = nres + 2'd1;
                cnt_v          = sat_inc(cnt_v);
            end
        end

        if (end_v) begin
            res_v[nres[0]]      = make_result(CHAR_NUL, 1'b1, cnt_v);
            nres                = nres + 2'd1;
            escape_pending_next = 1'b0;
            octal_count_next    = 2'd0;
            octal_acc_next      = '0;
            cnt_v               = '0;
        end

        if (nres == 2'd2) begin
            res_v[1].run_last = 1'b1;
        end else if (nres == 2'd1) begin
            res_v[0].run_last = 1'b1;
        end

        emitted_next = cnt_v;
        push.count   = nres;
        push.first   = res_v[0];
        push.second  = res_v[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
            octal_count_reg    <= 2'd0;
            octal_acc_reg      <= '0;
            emitted_reg        <= '0;
        end else if (in_accept) begin
            escape_pending_reg <= escape_pending_next;
            octal_count_reg    <= octal_count_next;
            octal_acc_reg      <= octal_acc_next;
            emitted_reg        <= emitted_next;
        end
    end

endmodule

// ===== rtl/cesd_out_queue.sv =====
// ============================================================================
// cesd_out_queue: three-entry result queue
// Takes up to two results per request and hands them out one per cycle while
// out_ready is high; takes a new request while at most one result is still waiting.
// ============================================================================
module cesd_out_queue
    import cesd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    input  push_t   push,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    result_t    entry_reg [QUEUE_DEPTH];
    result_t    entry_next [QUEUE_DEPTH];
    logic [1:0] fill_reg, fill_next;
    logic [1:0] base;
    logic       pop;
    logic       take;

    assign out_valid  = (fill_reg != 2'd0);
    assign push_ready = (fill_reg <= 2'd1);
    assign out_result = entry_reg[0];
    assign pop        = out_valid && out_ready;
    assign take       = push_valid && push_ready;

    always_comb begin
        base = fill_reg - {1'b0, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1)) begin
                entry_next[i] = entry_reg[i + 1];
            end else begin
                entry_next[i] = entry_reg[i];
            end
            if (take && (push.count != 2'd0) && (2'(i) == base)) begin
                entry_next[i] = push.first;
            end
            if (take && (push.count == 2'd2) && (2'(i) == base + 2'd1)) begin
                entry_next[i] = push.second;
            end
        end
        fill_next = base + (take ? push.count : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

endmodule

// ===== rtl/c_escape_sequence_decoder_core.sv =====
// ============================================================================
// c_escape_sequence_decoder_core: C string escape decoder, top level
// Decodes C escape sequences in a NUL-terminated byte stream.
// ============================================================================
// Usage:
//   s_ channel takes one source byte per request in s_tdata[7:0]; a zero
//   byte ends the string. m_ channel gives decoded characters and, for each
//   terminator, an end result with m_tlast high and the decoded length.
//   m_tuser marks the last result caused by one source byte.
// Output: each result is held in a queue register before it appears on m_.
// Throughput: one byte per cycle while m_tready is high and each byte gives
//   at most one result; a byte giving two results (unknown escape, short
//   octal run closed by a byte other than a backslash) holds s_tready low
//   until at most one result waits in the three-entry result queue.
// Reset: aresetn low clears the escape state, the length counter and the
//   queue; results still queued are dropped.
// Stall: with m_tready low the queue fills; s_tready drops once two or more
//   results wait, and nothing is lost.
// ============================================================================
module c_escape_sequence_decoder_core
    import cesd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] decoded_length
    output logic        m_tlast,
    output logic        m_tuser    // [0] run_last
);

    push_t   push;
    result_t result;
    logic    accept;

    assign accept = s_tvalid && s_tready;

    cesd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_byte   (s_tdata),
        .push      (push)
    );

    cesd_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push       (push),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {result.decoded_length, result.out_byte};
    assign m_tlast = result.string_end;
    assign m_tuser = result.run_last;

endmodule

// ===== verif/c_escape_sequence_decoder_core_tb.sv =====
// ============================================================================
// c_escape_sequence_decoder_core_tb: self-checking bench for the escape decoder
// Sends source bytes with random gaps and receiver stalls. A behavioral
// decoder in the bench decodes the same stream and queues the results it
// expects. Each result is compared field by field with the oldest entry.
// ============================================================================
module c_escape_sequence_decoder_core_tb;
    import cesd_pkg::*;

    localparam int LEN_CAP      = (LENGTH_BITS >= 16) ? 65535 : (1 << LENGTH_BITS) - 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 1600;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SEVEN   = 8'h37;
    localparam logic [7:0] CHAR_LOWER_Q = 8'h71;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] decoded_length
    logic        m_tlast;
    logic        m_tuser;   // [0] run_last

    logic        esc_pending = 1'b0;
    logic [1:0]  oct_count   = 2'd0;
    logic [7:0]  oct_value   = 8'd0;
    logic [15:0] char_count  = 16'd0;

    result_t     step_first;
    result_t     step_second;
    int          step_n;
    result_t     decoded_q[$];
    result_t     want;

    int          err_count    = 0;
    int          stall_cycles = 0;
    int          items_sent   = 0;
    bit          src_idle     = 1'b0;
    bit          sink_idle    = 1'b0;
    bit          hold_req     = 1'b0;

    c_escape_sequence_decoder_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_result(input logic [7:0] ch, input logic fin, input logic [15:0] len);
        result_t r;
        r.out_byte       = ch;
        r.string_end     = fin;
        r.decoded_length = len;
        r.run_last       = 1'b0;
        if (step_n == 0) step_first = r;
        else step_second = r;
        step_n++;
    endtask

    task automatic emit_char(input logic [7:0] ch);
        add_result(ch, 1'b0, 16'd0);
        if (char_count < LEN_CAP) char_count = char_count + 16'd1;
    endtask

    task automatic emit_end();
        add_result(CHAR_NUL, 1'b1, char_count);
        esc_pending = 1'b0;
        oct_count   = 2'd0;
        oct_value   = 8'd0;
        char_count  = 16'd0;
    endtask

    task automatic take_plain(input logic [7:0] b);
        if (b == CHAR_NUL) emit_end();
        else if (b == CHAR_BACKSLASH) esc_pending = 1'b1;
        else emit_char(b);
    endtask

    task automatic decode_expected(input logic [7:0] b);
        logic is_oct;
        is_oct = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
        step_n = 0;
        if (oct_count != 2'd0) begin
            if (is_oct) begin
                oct_value = {oct_value[4:0], 3'b000} + (b - CHAR_ZERO);
                if (oct_count == 2'd2) begin
                    oct_count = 2'd0;
                    emit_char(oct_value);
                    oct_value = 8'd0;
                end else begin
                    oct_count = oct_count + 2'd1;
                end
            end else begin
                oct_count = 2'd0;
                emit_char(oct_value);
                oct_value = 8'd0;
                take_plain(b);
            end
        end else if (esc_pending) begin
            esc_pending = 1'b0;
            if (is_oct) begin
                oct_count = 2'd1;
                oct_value = b - CHAR_ZERO;
            end else begin
                case (b)
                    CHAR_NUL:       emit_end();
                    CHAR_LOWER_A:   emit_char(CTRL_BEL);
                    CHAR_LOWER_B:   emit_char(CTRL_BS);
                    CHAR_LOWER_F:   emit_char(CTRL_FF);
                    CHAR_LOWER_N:   emit_char(CTRL_LF);
                    CHAR_LOWER_R:   emit_char(CTRL_CR);
                    CHAR_LOWER_T:   emit_char(CTRL_HT);
                    CHAR_LOWER_V:   emit_char(CTRL_VT);
                    CHAR_QUOTE,
                    CHAR_BACKSLASH: emit_char(b);
                    default: begin
                        emit_char(CHAR_BACKSLASH);
                        emit_char(b);
                    end
                endcase
            end
        end else begin
            take_plain(b);
        end
        if (step_n == 1) begin
            step_first.run_last = 1'b1;
            decoded_q.push_back(step_first);
        end else if (step_n == 2) begin
            step_second.run_last = 1'b1;
            decoded_q.push_back(step_first);
            decoded_q.push_back(step_second);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_expected(b);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_token();
        int          kind;
        int          digits;
        logic [7:0]  ch;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            ch = 8'($urandom_range(1, 255));
            send_byte(ch);
        end else if (kind < 55) begin
            case ($urandom_range(0, 8))
                0:       ch = CHAR_LOWER_A;
                1:       ch = CHAR_LOWER_B;
                2:       ch = CHAR_LOWER_F;
                3:       ch = CHAR_LOWER_N;
                4:       ch = CHAR_LOWER_R;
                5:       ch = CHAR_LOWER_T;
                6:       ch = CHAR_LOWER_V;
                7:       ch = CHAR_QUOTE;
                default: ch = CHAR_BACKSLASH;
            endcase
            send_byte(CHAR_BACKSLASH);
            send_byte(ch);
        end else if (kind < 75) begin
            digits = $urandom_range(1, 3);
            send_byte(CHAR_BACKSLASH);
            repeat (digits) send_byte(CHAR_ZERO + 8'($urandom_range(0, 7)));
        end else if (kind < 82) begin
            ch = 8'($urandom_range(0, 255));
            send_byte(CHAR_BACKSLASH);
            send_byte(ch);
        end else if (kind < 90) begin
            send_byte(CHAR_NUL);
        end else begin
            ch = 8'($urandom_range(0, 255));
            send_byte(ch);
        end
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CHAR_NUL);
        send_byte(CHAR_NUL);
        wait_drain();
    endtask

    task automatic test_control_escapes();
        send_text("\\a\\b\\f\\n\\r\\t\\v\\\"\\\\");
        send_byte(CHAR_NUL);
        wait_drain();
    endtask

    task automatic test_octal_runs();
        send_text("\\0Z\\377\\777\\12\\1\\n\\1234");
        send_byte(CHAR_NUL);
        send_text("\\7");
        send_byte(CHAR_NUL);
        wait_drain();
    endtask

    task automatic test_unknown_escapes();
        send_byte(CHAR_BACKSLASH);
        send_byte(CHAR_LOWER_Q);
        send_byte(CHAR_BACKSLASH);
        send_byte(8'hFF);
        send_byte(CHAR_BACKSLASH);
        send_byte(8'h01);
        send_byte(CHAR_BACKSLASH);
        send_byte(CHAR_NUL);
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        src_idle = 1'b0;
        hold_req = 1'b1;
        repeat (30) begin
            send_byte(CHAR_BACKSLASH);
            send_byte(CHAR_LOWER_Q);
        end
        send_byte(CHAR_NUL);
        wait_drain();
        src_idle = 1'b1;
    endtask

    task automatic test_random_stream();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            src_idle  = (phase != 1) && (phase != 3);
            sink_idle = (phase != 2) && (phase != 3);
            target    = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target) send_token();
            send_byte(CHAR_NUL);
            wait_drain();
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // receiver: random stalls, or one long hold when requested
    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                gap = sink_idle ? pick_gap() : 0;
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: result data %h last %b user %b with no request pending",
                         $time, m_tdata, m_tlast, m_tuser);
                err_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata[7:0] !== want.out_byte) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, want.out_byte, m_tdata[7:0]);
                    err_count++;
                end
                if (m_tlast !== want.string_end) begin
                    $display("%0t: string_end expected %b got %b",
                             $time, want.string_end, m_tlast);
                    err_count++;
                end
                if (m_tdata[23:8] !== want.decoded_length) begin
                    $display("%0t: decoded_length expected %0d got %0d",
                             $time, want.decoded_length, m_tdata[23:8]);
                    err_count++;
                end
                if (m_tuser !== want.run_last) begin
                    $display("%0t: run_last expected %b got %b",
                             $time, want.run_last, m_tuser);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_bytes();
        test_control_escapes();
        test_octal_runs();
        test_unknown_escapes();
        test_output_backpressure();
        test_random_stream();

        if (decoded_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cesd_pkg.sv
rtl/cesd_decode.sv
rtl/cesd_out_queue.sv
rtl/c_escape_sequence_decoder_core.sv
verif/c_escape_sequence_decoder_core_tb.sv
